// File: src/bdct_pkg.sv
// ============================================================================
// bdct_pkg
// Shared types, constants and helpers of the block dark-count threshold.
// ============================================================================
package bdct_pkg;

    // Parameter defaults
    localparam int DEF_MAX_GRID_COLS   = 16;
    localparam int DEF_MAX_IMAGE_WIDTH = 4096;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_GEO_W  = 13;
    localparam int CFG_GRID_W = 5;
    localparam int CNT_W      = 25;
    localparam int CELL_POS_W = 12;
    localparam int ROW_W      = 5;
    localparam int OUT_IDX_W  = 4;
    localparam int CLAMP_W    = 15;

    // Clamp limits of the cell geometry and the grid height
    localparam int CELL_MAX      = 4096;
    localparam int GRID_ROWS_MAX = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_CELL_WIDTH     = 3'd1,
        REG_CELL_HEIGHT    = 3'd2,
        REG_GRID_COLS      = 3'd3,
        REG_GRID_ROWS      = 3'd4,
        REG_MIN_DARK_COUNT = 3'd5,
        REG_DARK_LEVEL     = 3'd6
    } t_cfg_reg;

    // Reset values of the registers (geometry values stored as value - 1)
    localparam logic [CELL_POS_W-1:0] RST_CELL_M1    = '0;
    localparam logic [3:0]            RST_GRID_M1    = 4'd4;
    localparam int                    RST_IMAGE_M1   = 4;
    localparam logic [CNT_W-1:0]      RST_MIN_DARK   = 25'd1;
    localparam logic [PIX_W-1:0]      RST_DARK_LEVEL = 8'd96;

    // Per-pixel word handed from the position tracker to the counter stage
    typedef struct packed {
        logic                 restart;  // first pixel of a new image
        logic                 cnt;      // pixel lies inside the grid
        logic                 start;    // first pixel of its cell
        logic                 finish;   // last pixel of its cell
        logic                 dark;     // pixel at or below the dark level
        logic                 last;     // pixel lies in the bottom-right cell
        logic [OUT_IDX_W-1:0] col;
        logic [OUT_IDX_W-1:0] row;
    } t_pix_info;

    // Clamp a register value to [1, hi] and return it minus one
    function automatic logic [CLAMP_W-1:0] clamp_m1(input logic [CFG_GEO_W-1:0] v,
                                                    input logic [CLAMP_W-1:0]   hi);
        logic [CLAMP_W-1:0] ve;
        ve = CLAMP_W'(v);
        if (ve == '0) begin
            return '0;
        end else if (ve > hi) begin
            return hi - 1'b1;
        end else begin
            return ve - 1'b1;
        end
    endfunction

endpackage

// File: src/block_dark_count_threshold.sv
// ============================================================================
// block_dark_count_threshold
// Grid downsample and binarize: per-cell dark pixel count against a minimum.
// ============================================================================
// Pixels enter in raster order at one word per clock cycle unless the output
// stalls, with no bubbles needed between words. Each cell's bit passes the
// stage 1 and output registers. The running counts of one cell row live in a
// small memory of MAX_GRID_COLS entries that is read when a pixel is accepted
// and written back from stage 1, with forwarding when consecutive pixels hit
// the same cell column; that read-modify-write sets the one-word-per-cycle
// figure. Per-entry valid bits clear the counts on reset and on a first pixel
// at once, so the block needs no clearing pass. A stalled output holds at
// most one finished word and one word in flight before input stalls.
// ============================================================================
module block_dark_count_threshold #(
    parameter int MAX_GRID_COLS   = bdct_pkg::DEF_MAX_GRID_COLS,
    parameter int MAX_IMAGE_WIDTH = bdct_pkg::DEF_MAX_IMAGE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bdct_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_first_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_cell_dark,
    output logic [bdct_pkg::OUT_IDX_W-1:0]      o_cell_col,
    output logic [bdct_pkg::OUT_IDX_W-1:0]      o_cell_row,
    output logic                                o_last_cell
);
    import bdct_pkg::*;

    localparam int CCW = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;

    logic           fire;
    logic           s1_free;
    t_pix_info      info;
    logic [CCW-1:0] rd_addr;

    // Take a word whenever the counter stage can move on
    assign o_ready = s1_free;
    assign fire    = i_valid && s1_free;

    bdct_pos #(
        .MAX_GRID_COLS   (MAX_GRID_COLS),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH),
        .CCW             (CCW)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_fire        (fire),
        .i_pixel       (i_pixel),
        .i_first_pixel (i_first_pixel),
        .o_info        (info),
        .o_rd_addr     (rd_addr)
    );

    bdct_acc #(
        .MAX_GRID_COLS (MAX_GRID_COLS),
        .CCW           (CCW)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_info      (info),
        .i_rd_addr   (rd_addr),
        .o_s1_free   (s1_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cell_dark (o_cell_dark),
        .o_cell_col  (o_cell_col),
        .o_cell_row  (o_cell_row),
        .o_last_cell (o_last_cell)
    );

endmodule

// File: src/bdct_ram.sv
// ============================================================================
// bdct_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module bdct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bdct_pos.sv
// ============================================================================
// bdct_pos
// Raster position tracker: geometry registers, pixel/cell position counters
// and the per-pixel classification handed to the counter stage.
// ============================================================================
module bdct_pos #(
    parameter int MAX_GRID_COLS   = bdct_pkg::DEF_MAX_GRID_COLS,
    parameter int MAX_IMAGE_WIDTH = bdct_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int CCW             = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_fire,
    input  logic [bdct_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_first_pixel,
    output bdct_pkg::t_pix_info                 o_info,
    output logic [CCW-1:0]                      o_rd_addr
);
    import bdct_pkg::*;

    localparam int PW = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
    localparam logic [CLAMP_W-1:0] IW_HI   = CLAMP_W'(MAX_IMAGE_WIDTH);
    localparam logic [CLAMP_W-1:0] CELL_HI = CLAMP_W'(CELL_MAX);
    localparam logic [CLAMP_W-1:0] GC_HI   = CLAMP_W'(MAX_GRID_COLS);
    localparam logic [CLAMP_W-1:0] GR_HI   = CLAMP_W'(GRID_ROWS_MAX);

    // Geometry registers
    logic [PW-1:0]         r_iw_m1;
    logic [CELL_POS_W-1:0] r_cw_m1;
    logic [CELL_POS_W-1:0] r_ch_m1;
    logic [CCW-1:0]        r_gc_m1;
    logic [3:0]            r_gr_m1;
    logic [PIX_W-1:0]      r_dark_level;

    // Position state
    logic [PW-1:0]         r_pos,  n_pos;
    logic [CELL_POS_W-1:0] r_cic,  n_cic;
    logic [CELL_POS_W-1:0] r_ric,  n_ric;
    logic [CCW-1:0]        r_col,  n_col;
    logic [ROW_W-1:0]      r_row,  n_row;
    logic                  r_past, n_past;

    logic [PW-1:0]         eff_pos;
    logic [CELL_POS_W-1:0] eff_cic;
    logic [CELL_POS_W-1:0] eff_ric;
    logic [CCW-1:0]        eff_col;
    logic [ROW_W-1:0]      eff_row;
    logic                  eff_past;
    logic                  in_grid;
    logic                  cic_end;
    logic                  ric_end;
    logic [CFG_GEO_W-1:0]  cfg_geo;
    logic [CFG_GEO_W-1:0]  cfg_grid;

    assign cfg_geo  = i_cfg_data[CFG_GEO_W-1:0];
    assign cfg_grid = CFG_GEO_W'(i_cfg_data[CFG_GRID_W-1:0]);

    // Take register writes; geometry values are clamped and stored as value - 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw_m1      <= PW'(RST_IMAGE_M1);
            r_cw_m1      <= RST_CELL_M1;
            r_ch_m1      <= RST_CELL_M1;
            r_gc_m1      <= CCW'(RST_GRID_M1);
            r_gr_m1      <= RST_GRID_M1;
            r_dark_level <= RST_DARK_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: r_iw_m1      <= PW'(clamp_m1(cfg_geo, IW_HI));
                REG_CELL_WIDTH:  r_cw_m1      <= CELL_POS_W'(clamp_m1(cfg_geo, CELL_HI));
                REG_CELL_HEIGHT: r_ch_m1      <= CELL_POS_W'(clamp_m1(cfg_geo, CELL_HI));
                REG_GRID_COLS:   r_gc_m1      <= CCW'(clamp_m1(cfg_grid, GC_HI));
                REG_GRID_ROWS:   r_gr_m1      <= 4'(clamp_m1(cfg_grid, GR_HI));
                REG_DARK_LEVEL:  r_dark_level <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart the position ahead of a first pixel
    always_comb begin
        eff_pos  = i_first_pixel ? '0   : r_pos;
        eff_cic  = i_first_pixel ? '0   : r_cic;
        eff_ric  = i_first_pixel ? '0   : r_ric;
        eff_col  = i_first_pixel ? '0   : r_col;
        eff_row  = i_first_pixel ? '0   : r_row;
        eff_past = i_first_pixel ? 1'b0 : r_past;
    end

    // Classify the pixel against the grid
    assign in_grid = !eff_past && (eff_col <= r_gc_m1) && (eff_row <= {1'b0, r_gr_m1});
    assign cic_end = eff_cic >= r_cw_m1;
    assign ric_end = eff_ric >= r_ch_m1;

    always_comb begin
        o_info.restart = i_first_pixel;
        o_info.cnt     = in_grid;
        o_info.start   = (eff_cic == '0) && (eff_ric == '0);
        o_info.finish  = in_grid && cic_end && ric_end;
        o_info.dark    = i_pixel <= r_dark_level;
        o_info.last    = (eff_col == r_gc_m1) && (eff_row == {1'b0, r_gr_m1});
        o_info.col     = OUT_IDX_W'(eff_col);
        o_info.row     = eff_row[OUT_IDX_W-1:0];
    end

    assign o_rd_addr = eff_col;

    // Advance the raster position
    always_comb begin
        n_pos  = eff_pos;
        n_cic  = eff_cic;
        n_ric  = eff_ric;
        n_col  = eff_col;
        n_row  = eff_row;
        n_past = eff_past;
        if (eff_pos >= r_iw_m1) begin
            n_pos  = '0;
            n_cic  = '0;
            n_col  = '0;
            n_past = 1'b0;
            if (eff_row <= {1'b0, r_gr_m1}) begin
                if (ric_end) begin
                    n_ric = '0;
                    n_row = eff_row + 1'b1;
                end else begin
                    n_ric = eff_ric + 1'b1;
                end
            end
        end else begin
            n_pos = eff_pos + 1'b1;
            if (!eff_past) begin
                if (cic_end) begin
                    n_cic = '0;
                    if (eff_col >= r_gc_m1) begin
                        n_past = 1'b1;
                    end else begin
                        n_col = eff_col + 1'b1;
                    end
                end else begin
                    n_cic = eff_cic + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cic  <= '0;
            r_ric  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_past <= 1'b0;
        end else if (i_fire) begin
            r_pos  <= n_pos;
            r_cic  <= n_cic;
            r_ric  <= n_ric;
            r_col  <= n_col;
            r_row  <= n_row;
            r_past <= n_past;
        end
    end

    // Position moves only on an accepted word
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_pos) && $stable(r_row) && $stable(r_col))
        else $error("position changed without an accepted word");

    // A first pixel leaves the position at most one step past the origin
    a_restart_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_first_pixel |=> r_pos <= 1 && r_cic <= 1 && r_row <= 1)
        else $error("first pixel did not restart the position");

endmodule

// File: src/bdct_acc.sv
// ============================================================================
// bdct_acc
// Dark-count stage: read-modify-write of the per-column counter memory with
// forwarding, per-entry valid bits, threshold compare and output register.
// ============================================================================
module bdct_acc #(
    parameter int MAX_GRID_COLS = bdct_pkg::DEF_MAX_GRID_COLS,
    parameter int CCW           = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_fire,
    input  bdct_pkg::t_pix_info                 i_info,
    input  logic [CCW-1:0]                      i_rd_addr,
    output logic                                o_s1_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_cell_dark,
    output logic [bdct_pkg::OUT_IDX_W-1:0]      o_cell_col,
    output logic [bdct_pkg::OUT_IDX_W-1:0]      o_cell_row,
    output logic                                o_last_cell
);
    import bdct_pkg::*;

    logic [CNT_W-1:0]         r_min;

    // Stage 1: word waiting for its counter read
    logic                     r_s1_valid;
    t_pix_info                r_s1;
    logic [CCW-1:0]           r_s1_addr;
    logic                     r_fwd_hit;
    logic [CNT_W-1:0]         r_fwd_data;
    logic                     r_ent_ok;

    logic [MAX_GRID_COLS-1:0] r_vbits, n_vbits;

    logic                     r_out_valid;
    logic                     r_out_dark;
    logic [OUT_IDX_W-1:0]     r_out_col;
    logic [OUT_IDX_W-1:0]     r_out_row;
    logic                     r_out_last;

    logic [CNT_W-1:0]         rd_data;
    logic [CNT_W-1:0]         cur_cnt;
    logic [CNT_W-1:0]         new_cnt;
    logic                     s1_fire;
    logic                     wr_en;

    // Minimum dark count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RST_MIN_DARK;
        end else if (i_cfg_we && (i_cfg_idx == REG_MIN_DARK_COUNT)) begin
            r_min <= i_cfg_data[CNT_W-1:0];
        end
    end

    bdct_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_GRID_COLS),
        .AW    (CCW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (new_cnt),
        .i_re    (i_fire),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_data)
    );

    // Pick forwarded, stored or cleared count, then update with saturation
    always_comb begin
        if (r_fwd_hit) begin
            cur_cnt = r_fwd_data;
        end else if (r_ent_ok) begin
            cur_cnt = rd_data;
        end else begin
            cur_cnt = '0;
        end
        if (r_s1.start) begin
            new_cnt = CNT_W'(r_s1.dark);
        end else if (cur_cnt != COUNT_MAX) begin
            new_cnt = cur_cnt + CNT_W'(r_s1.dark);
        end else begin
            new_cnt = cur_cnt;
        end
    end

    // Stage 1 advances unless its result finds the output register full
    assign s1_fire   = r_s1_valid && (!r_s1.finish || !r_out_valid || i_ready);
    assign wr_en     = s1_fire && r_s1.cnt;
    assign o_s1_free = !r_s1_valid || s1_fire;

    // Valid bits: set on write-back, drop all on image restart
    always_comb begin
        n_vbits = r_vbits;
        if (wr_en) begin
            n_vbits[r_s1_addr] = 1'b1;
        end
        if (i_fire && i_info.restart) begin
            n_vbits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_vbits    <= '0;
            r_fwd_hit  <= 1'b0;
            r_ent_ok   <= 1'b0;
        end else begin
            r_vbits <= n_vbits;
            if (i_fire) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= !i_info.restart && wr_en && (r_s1_addr == i_rd_addr);
                r_ent_ok   <= !i_info.restart && r_vbits[i_rd_addr];
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Capture the issued word and the write-back that overlaps its read
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s1       <= i_info;
            r_s1_addr  <= i_rd_addr;
            r_fwd_data <= new_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.finish) begin
            r_out_dark <= new_cnt >= r_min;
            r_out_col  <= r_s1.col;
            r_out_row  <= r_s1.row;
            r_out_last <= r_s1.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cell_dark = r_out_dark;
    assign o_cell_col  = r_out_col;
    assign o_cell_row  = r_out_row;
    assign o_last_cell = r_out_last;

    // A restart wins over a same-cycle write-back
    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_info.restart |=> r_vbits == '0)
        else $error("valid bits survived an image restart");

    // A finished cell blocked by a full output register stays in stage 1
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1.finish && r_out_valid && !i_ready |=> r_s1_valid && $stable(r_s1))
        else $error("finished cell lost while output was stalled");

    // A finished cell always reaches the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1.finish |=> r_out_valid)
        else $error("finished cell did not load the output register");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// ============================================================================
// tb
// Testbench of block_dark_count_threshold: directed and random raster images are
// streamed through the block, and each cell bit it returns is matched in order
// against a cycle-free model of the grid counters kept in a small scoreboard class.
// ============================================================================

import bdct_pkg::*;

typedef struct packed {
    logic                 dark;
    logic [OUT_IDX_W-1:0] col;
    logic [OUT_IDX_W-1:0] row;
    logic                 last;
} t_cell_word;

class dark_cell_board;
    // Register copies, raw as written
    logic [CFG_GEO_W-1:0]  image_width, cell_width, cell_height;
    logic [CFG_GRID_W-1:0] grid_cols, grid_rows;
    logic [CNT_W-1:0]      min_dark;
    logic [PIX_W-1:0]      dark_level;

    // Raster position and per-column running counts
    logic [CELL_POS_W-1:0] col_pos, col_in_cell, row_in_cell;
    logic [OUT_IDX_W-1:0]  cell_col;
    logic [ROW_W-1:0]      cell_row;
    logic [CNT_W-1:0]      dark_counts [DEF_MAX_GRID_COLS];
    bit                    past_grid;

    t_cell_word            expected_cells [$];
    int                    errors;

    function new();
        image_width = 13'd5;
        cell_width  = 13'd1;
        cell_height = 13'd1;
        grid_cols   = 5'd5;
        grid_rows   = 5'd5;
        min_dark    = 25'd1;
        dark_level  = 8'd96;
        errors      = 0;
        restart();
    endfunction

    function void restart();
        col_pos     = '0;
        col_in_cell = '0;
        row_in_cell = '0;
        cell_col    = '0;
        cell_row    = '0;
        past_grid   = 1'b0;
        foreach (dark_counts[i]) dark_counts[i] = '0;
    endfunction

    function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_IMAGE_WIDTH:    image_width = value[CFG_GEO_W-1:0];
            REG_CELL_WIDTH:     cell_width  = value[CFG_GEO_W-1:0];
            REG_CELL_HEIGHT:    cell_height = value[CFG_GEO_W-1:0];
            REG_GRID_COLS:      grid_cols   = value[CFG_GRID_W-1:0];
            REG_GRID_ROWS:      grid_rows   = value[CFG_GRID_W-1:0];
            REG_MIN_DARK_COUNT: min_dark    = value[CNT_W-1:0];
            REG_DARK_LEVEL:     dark_level  = value[PIX_W-1:0];
            default: ;
        endcase
    endfunction

    static function int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the grid by one accepted pixel; queue the cell bit it finishes
    function void note_pixel(logic [PIX_W-1:0] pix, logic first);
        int         iw, cw, ch, gc, gr;
        logic       dark;
        t_cell_word w;
        iw = clamp(int'(image_width), 1, DEF_MAX_IMAGE_WIDTH);
        cw = clamp(int'(cell_width), 1, CELL_MAX);
        ch = clamp(int'(cell_height), 1, CELL_MAX);
        gc = clamp(int'(grid_cols), 1, DEF_MAX_GRID_COLS);
        gr = clamp(int'(grid_rows), 1, GRID_ROWS_MAX);

        if (first) restart();

        if (!past_grid && int'(cell_col) < gc && int'(cell_row) < gr) begin
            dark = (pix <= dark_level);
            // Load the count on a cell's first pixel, saturate otherwise
            if (col_in_cell == '0 && row_in_cell == '0) begin
                dark_counts[cell_col] = CNT_W'(dark);
            end else if (dark_counts[cell_col] != COUNT_MAX) begin
                dark_counts[cell_col] = dark_counts[cell_col] + CNT_W'(dark);
            end
            if (int'(col_in_cell) >= cw - 1 && int'(row_in_cell) >= ch - 1) begin
                w.dark = (dark_counts[cell_col] >= min_dark);
                w.col  = cell_col;
                w.row  = cell_row[OUT_IDX_W-1:0];
                w.last = (int'(cell_col) == gc - 1 && int'(cell_row) == gr - 1);
                expected_cells.push_back(w);
            end
        end

        // Step the raster position, wrapping at the end of an image row
        if (int'(col_pos) >= iw - 1) begin
            col_pos     = '0;
            col_in_cell = '0;
            cell_col    = '0;
            past_grid   = 1'b0;
            if (int'(cell_row) < gr) begin
                if (int'(row_in_cell) >= ch - 1) begin
                    row_in_cell = '0;
                    cell_row    = cell_row + 1'b1;
                end else begin
                    row_in_cell = row_in_cell + 1'b1;
                end
            end
        end else begin
            col_pos = col_pos + 1'b1;
            if (!past_grid) begin
                if (int'(col_in_cell) >= cw - 1) begin
                    col_in_cell = '0;
                    if (int'(cell_col) >= gc - 1) past_grid = 1'b1;
                    else cell_col = cell_col + 1'b1;
                end else begin
                    col_in_cell = col_in_cell + 1'b1;
                end
            end
        end
    endfunction

    function void report(string field, int want, int got);
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_cell(t_cell_word got);
        t_cell_word want;
        if (expected_cells.size() == 0) begin
            errors++;
            $display("%0t: cell expected none actual col %0d row %0d", $time,
                     got.col, got.row);
            return;
        end
        want = expected_cells.pop_front();
        if (got.dark != want.dark) report("cell_dark", want.dark, got.dark);
        if (got.col != want.col)   report("cell_col", want.col, got.col);
        if (got.row != want.row)   report("cell_row", want.row, got.row);
        if (got.last != want.last) report("last_cell", want.last, got.last);
    endfunction

    function int pending();
        return expected_cells.size();
    endfunction
endclass

module tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_WORDS = 700;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_pixel;
    logic                  i_first_pixel;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_cell_dark;
    logic [OUT_IDX_W-1:0]  o_cell_col;
    logic [OUT_IDX_W-1:0]  o_cell_row;
    logic                  o_last_cell;

    dark_cell_board board;
    bit             offering;
    bit             send_gaps;
    bit             long_hold_req;
    int             cur_dark_level;
    int             words_sent;
    int             idle_cycles = 0;

    block_dark_count_threshold uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .i_first_pixel (i_first_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_dark   (o_cell_dark),
        .o_cell_col    (o_cell_col),
        .o_cell_row    (o_cell_row),
        .o_last_cell   (o_last_cell)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL block_dark_count_threshold");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: check accepted words, then pick the next ready
    initial begin
        int         stall_left, rx_mode, mode_left, r;
        t_cell_word got;
        i_ready    = 1'b0;
        stall_left = 0;
        rx_mode    = 0;
        mode_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = {o_cell_dark, o_cell_col, o_cell_row, o_last_cell};
                board.check_cell(got);
            end
            if (long_hold_req) begin
                stall_left    = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (rx_mode == 0) begin
                i_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    stall_left = (r >= 97) ? $urandom_range(10, 40) : $urandom_range(0, 2);
                end
            end
        end
    end

    // Offer one pixel word, hold it until taken, then maybe pause
    task automatic send_word(input logic [PIX_W-1:0] pix, input logic first);
        int gap, r;
        i_valid       <= 1'b1;
        i_pixel       <= pix;
        i_first_pixel <= first;
        offering      = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        board.note_pixel(pix, first);
        words_sent++;
        gap = 0;
        if (send_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(10, 40);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid  <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every queued cell bit has come back, then let the pipe settle
    task automatic drain();
        if (offering) begin
            i_valid  <= 1'b0;
            offering = 1'b0;
        end
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        board.write_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic configure(input int iw, input int cw, input int ch, input int gc,
                             input int gr, input int mn, input int dl);
        write_reg(REG_IMAGE_WIDTH, iw);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, ch);
        write_reg(REG_GRID_COLS, gc);
        write_reg(REG_GRID_ROWS, gr);
        write_reg(REG_MIN_DARK_COUNT, mn);
        write_reg(REG_DARK_LEVEL, dl);
        i_cfg_we       <= 1'b0;
        cur_dark_level = dl;
    endtask

    // Limit a value to the pixel range
    function automatic int StdClamp(int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    // Favor values right around the dark level, plus both ends of the range
    function automatic logic [PIX_W-1:0] pick_pixel();
        int r, v;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2, 3, 4, 5: begin
                v = cur_dark_level + int'($urandom_range(0, 2)) - 1;
                return PIX_W'(StdClamp(v));
            end
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Stream one image: whole (0), cut short (1) or with stray restarts (2)
    task automatic send_image(input int iw, input int rows, input int style);
        int   total, cut, k;
        logic first;
        total = iw * rows;
        cut   = (style == 1) ? $urandom_range(1, total) : total;
        for (k = 0; k < cut; k++) begin
            if (style == 2) first = ($urandom_range(0, 19) == 0);
            else first = (k == 0);
            send_word(pick_pixel(), first);
        end
    endtask

    // Register value for an effective setting, sometimes out of range
    function automatic int encode(int eff, int max_eff, int max_raw);
        if (eff == 1 && $urandom_range(0, 3) == 0) return 0;
        if (eff == max_eff && $urandom_range(0, 1) == 1)
            return $urandom_range(max_eff + 1, max_raw);
        return eff;
    endfunction

    task automatic random_phase();
        int gc, gr, cw, ch, iw, rows, mn, dl, r, style;
        gc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
        gr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
        cw = $urandom_range(1, 4);
        ch = $urandom_range(1, 3);
        r  = $urandom_range(0, 9);
        if (r < 7) iw = gc * cw + $urandom_range(0, 2);
        else if (r < 9) iw = $urandom_range(1, gc * cw);
        else iw = $urandom_range(1, gc * cw + 5);
        // Keep images short
        while (gr > 1 && iw * (gr * ch + 2) > 320) gr--;
        rows = gr * ch + $urandom_range(0, 2);
        r = $urandom_range(0, 9);
        case (r)
            0:       mn = 0;
            1:       mn = cw * ch;
            2:       mn = ($urandom_range(0, 1) == 1) ? 16777216 : int'(COUNT_MAX);
            3:       mn = cw * ch + 1;
            default: mn = $urandom_range(1, cw * ch);
        endcase
        r = $urandom_range(0, 9);
        dl = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255);
        send_gaps = ($urandom_range(0, 3) != 0);
        configure(encode(iw, DEF_MAX_IMAGE_WIDTH, 8191), encode(cw, CELL_MAX, 8191),
                  encode(ch, CELL_MAX, 8191), encode(gc, DEF_MAX_GRID_COLS, 31),
                  encode(gr, GRID_ROWS_MAX, 31), mn, dl);
        repeat ($urandom_range(1, 3)) begin
            r     = $urandom_range(0, 99);
            style = (r < 80) ? 0 : (r < 90) ? 1 : 2;
            send_image(iw, rows, style);
        end
        drain();
    endtask

    initial begin
        logic [PIX_W-1:0] opening [25];
        int               k, start;
        board          = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_IMAGE_WIDTH;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_pixel        = '0;
        i_first_pixel  = 1'b0;
        offering       = 1'b0;
        send_gaps      = 1'b1;
        long_hold_req  = 1'b0;
        cur_dark_level = 96;
        words_sent     = 0;
        opening = '{8'd0, 8'd255, 8'd96, 8'd97, 8'd95, 8'd1, 8'd254, 8'd128, 8'd0,
                    8'd96, 8'd97, 8'd255, 8'd50, 8'd200, 8'd96, 8'd97, 8'd0, 8'd255,
                    8'd10, 8'd100, 8'd96, 8'd95, 8'd97, 8'd255, 8'd0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a 5x5 grid of single-pixel cells around level 96
        for (k = 0; k < 25; k++) send_word(opening[k], k == 0);
        drain();

        // Full 16x16 grid from oversized grid registers; hold the output long
        send_gaps = 1'b0;
        configure(16, 1, 1, 31, 31, 1, 0);
        long_hold_req = 1'b1;
        send_image(16, 16, 0);
        drain();

        // All registers zero: every pixel is a one-cell image that always passes
        send_gaps = 1'b1;
        configure(0, 0, 0, 0, 0, 0, 0);
        repeat (10) send_image(1, 1, 0);
        drain();

        // Oversized image width: a wide cell inside one unwrapped row meets its minimum
        configure(8191, 200, 1, 1, 1, 200, 255);
        send_image(200, 1, 0);
        drain();

        // Oversized cell height in a one-pixel-wide image: the cell never finishes
        configure(1, 0, 8191, 1, 1, 16777216, 128);
        send_image(1, 150, 0);
        drain();

        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) random_phase();

        if (board.errors == 0) begin
            $display("PASS block_dark_count_threshold");
        end else begin
            $display("FAIL block_dark_count_threshold");
        end
        $finish;
    end

endmodule

// File: files.f
src/bdct_pkg.sv
src/bdct_ram.sv
src/bdct_pos.sv
src/bdct_acc.sv
src/block_dark_count_threshold.sv
bench/tb.sv
